[rtl/core/assert_macros.svh]
// Assertion helpers shared by the unpacker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define FWBU_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) else $error(msg);

// Check that the consequent holds in the same cycle as the antecedent.
`define FWBU_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define FWBU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/fwbu_pkg.sv]
`default_nettype none

package fwbu_pkg;

    localparam int MAX_VALUE_BITS = 64;
    localparam int WIDTH_BITS     = 7;
    localparam int OFFSET_BITS    = 3;
    localparam int COUNT_BITS     = 24;
    localparam int CFG_DATA_BITS  = 24;
    localparam int CFG_INDEX_BITS = 2;
    localparam int IQ_DEPTH       = 4;
    localparam int IQ_PTR_BITS    = 2;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_VALUE_WIDTH      = 2'd0,
        REG_START_BIT_OFFSET = 2'd1,
        REG_VALUE_COUNT      = 2'd2
    } t_reg_index;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
    } t_in;

    typedef struct packed {
        logic [63:0] value;
        logic        last_in_byte;
        logic        last_value;
    } t_out;

    typedef struct packed {
        logic [7:0]             data_byte;
        logic                   first_byte;
        logic [OFFSET_BITS-1:0] skip;
    } t_work;

    typedef struct packed {
        logic [WIDTH_BITS-1:0] width;
        logic [COUNT_BITS-1:0] count;
    } t_cfg;

    function automatic logic [WIDTH_BITS-1:0] eff_width(input logic [WIDTH_BITS-1:0] bpv);
        logic [WIDTH_BITS-1:0] w;
        w = bpv;
        if (w == '0) begin
            w = WIDTH_BITS'(1);
        end
        if (w > WIDTH_BITS'(MAX_VALUE_BITS)) begin
            w = WIDTH_BITS'(MAX_VALUE_BITS);
        end
        return w;
    endfunction

    function automatic logic [7:0] low_mask8(input logic [3:0] n);
        logic [8:0] t;
        t = (9'd1 << n) - 9'd1;
        return t[7:0];
    endfunction

endpackage

`default_nettype wire

[rtl/core/fixed_width_bit_unpacker.sv]
// MSB-first fixed-width bit unpacker.
// Input channel: present a packed byte and its first_byte flag on i_in_item and
// raise push; the byte is taken at an edge where push is high and full is low.
// Result channel: while empty is low, o_out_item holds the oldest value; raise
// pop to take it. Values come right-aligned with last_in_byte/last_value marks.
// Configuration: write i_cfg_wdata to register i_cfg_index with i_cfg_wr_en
// (0 value width, 1 start bit offset, 2 value count), only while idle.
// With the gatherer idle, a byte is written to the byte queue, the gatherer
// forms its first value combinationally and the result queue registers it. A
// four-entry byte queue feeds the bit gatherer, which handles one byte a cycle
// while that byte completes at most one value, and one value a cycle otherwise,
// as long as the result queue has room; a byte holds up to 8 values. Bytes past
// the value count are dropped. When the receiver stalls, a two-entry result
// queue fills, the gatherer halts and the byte queue holds up to four bytes,
// the stalled one among them, before full rises.
// Synchronous reset empties both queues, clears the accumulator, held bit count
// and value count, and restores width 8, offset 0 and value count 0.
`default_nettype none

module fixed_width_bit_unpacker (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  push,
    output logic                                 full,
    input  fwbu_pkg::t_in                        i_in_item,
    output logic                                 empty,
    input  wire                                  pop,
    output fwbu_pkg::t_out                       o_out_item,
    input  wire                                  i_cfg_wr_en,
    input  wire [fwbu_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  wire [fwbu_pkg::CFG_DATA_BITS-1:0]    i_cfg_wdata
);
    import fwbu_pkg::*;

    logic [WIDTH_BITS-1:0]  r_value_width;
    logic [OFFSET_BITS-1:0] r_start_offset;
    logic [COUNT_BITS-1:0]  r_value_count;

    t_cfg  w_cfg;
    t_work w_work;
    logic  w_work_valid;
    logic  w_work_pop;
    t_out  w_res;
    logic  w_res_valid;
    logic  w_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value_width  <= WIDTH_BITS'(8);
            r_start_offset <= '0;
            r_value_count  <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (t_reg_index'(i_cfg_index))
                REG_VALUE_WIDTH:      r_value_width  <= i_cfg_wdata[WIDTH_BITS-1:0];
                REG_START_BIT_OFFSET: r_start_offset <= i_cfg_wdata[OFFSET_BITS-1:0];
                REG_VALUE_COUNT:      r_value_count  <= i_cfg_wdata[COUNT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_cfg.width = eff_width(r_value_width);
    assign w_cfg.count = r_value_count;

    fwbu_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_in         (i_in_item),
        .i_offset     (r_start_offset),
        .o_work_valid (w_work_valid),
        .o_work       (w_work),
        .i_work_pop   (w_work_pop)
    );

    fwbu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work_valid (w_work_valid),
        .i_work       (w_work),
        .o_work_pop   (w_work_pop),
        .i_cfg        (w_cfg),
        .o_res_valid  (w_res_valid),
        .o_res        (w_res),
        .i_res_ready  (w_res_ready)
    );

    fwbu_rq u_rq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (w_res_valid),
        .o_res_ready (w_res_ready),
        .i_res       (w_res),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_out       (o_out_item)
    );

endmodule

`default_nettype wire

[rtl/core/fwbu_front.sv]
`default_nettype none
`include "assert_macros.svh"

module fwbu_front (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_push,
    output logic                              o_full,
    input  fwbu_pkg::t_in                     i_in,
    input  wire [fwbu_pkg::OFFSET_BITS-1:0]   i_offset,
    output logic                              o_work_valid,
    output fwbu_pkg::t_work                   o_work,
    input  wire                               i_work_pop
);
    import fwbu_pkg::*;

    localparam logic [IQ_PTR_BITS:0] IQ_FULL = (IQ_PTR_BITS+1)'(IQ_DEPTH);

    t_work                  r_mem [IQ_DEPTH];
    logic [IQ_PTR_BITS-1:0] r_wr_ptr;
    logic [IQ_PTR_BITS-1:0] r_rd_ptr;
    logic [IQ_PTR_BITS:0]   r_count;
    logic [IQ_PTR_BITS:0]   n_count;
    t_work                  n_work;
    logic                   w_push;
    logic                   w_pop;

    assign o_full       = (r_count == IQ_FULL);
    assign o_work_valid = (r_count != '0);
    assign o_work       = r_mem[r_rd_ptr];
    assign w_push       = i_push && !o_full;
    assign w_pop        = i_work_pop && o_work_valid;

    // classify: a first byte carries the skip amount
    always_comb begin
        n_work.data_byte  = i_in.data_byte;
        n_work.first_byte = i_in.first_byte;
        n_work.skip       = i_in.first_byte ? i_offset : '0;
    end

    always_comb begin
        n_count = r_count;
        case ({w_push, w_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= n_work;
        end
    end

    `FWBU_ASSERT_ALWAYS(a_iq_count_bound, i_clk, i_rst_n, r_count <= IQ_FULL, "input queue overflow")

endmodule

`default_nettype wire

[rtl/core/fwbu_back.sv]
`default_nettype none
`include "assert_macros.svh"

module fwbu_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_work_valid,
    input  fwbu_pkg::t_work  i_work,
    output logic             o_work_pop,
    input  fwbu_pkg::t_cfg   i_cfg,
    output logic             o_res_valid,
    output fwbu_pkg::t_out   o_res,
    input  wire              i_res_ready
);
    import fwbu_pkg::*;

    localparam logic [WIDTH_BITS-1:0] MAXW = WIDTH_BITS'(MAX_VALUE_BITS);

    logic [MAX_VALUE_BITS-1:0] r_acc;
    logic [WIDTH_BITS-1:0]     r_held;
    logic [COUNT_BITS-1:0]     r_emitted;
    logic                      r_mid;
    logic [3:0]                r_pos;

    logic [MAX_VALUE_BITS-1:0] n_acc;
    logic [WIDTH_BITS-1:0]     n_held;
    logic [COUNT_BITS-1:0]     n_emitted;
    logic                      n_mid;
    logic [3:0]                n_pos;

    logic                      w_new;
    logic [MAX_VALUE_BITS-1:0] eff_acc;
    logic [WIDTH_BITS-1:0]     eff_held;
    logic [COUNT_BITS-1:0]     eff_emit;
    logic [3:0]                eff_pos;
    logic [3:0]                w_avail;
    logic                      w_done;
    logic [WIDTH_BITS-1:0]     w_need;
    logic                      w_complete;
    logic [3:0]                w_k;
    logic [3:0]                w_shr;
    logic [7:0]                w_chunk;
    logic [MAX_VALUE_BITS-1:0] w_acc_new;
    logic [3:0]                w_pos_next;
    logic [3:0]                w_rem;
    logic [COUNT_BITS-1:0]     w_emit_next;
    logic                      w_below;
    logic                      w_more;
    logic [7:0]                w_tail;
    logic [MAX_VALUE_BITS-1:0] w_mask;

    always_comb begin
        w_new       = !r_mid && i_work.first_byte;
        eff_acc     = w_new ? '0 : r_acc;
        eff_held    = w_new ? '0 : r_held;
        eff_emit    = w_new ? '0 : r_emitted;
        eff_pos     = r_mid ? r_pos : {1'b0, i_work.skip};
        w_avail     = 4'd8 - eff_pos;
        w_done      = (eff_emit >= i_cfg.count);
        w_need      = (eff_held >= i_cfg.width) ? WIDTH_BITS'(1) : (i_cfg.width - eff_held);
        w_complete  = (w_need <= {3'b000, w_avail});
        w_k         = w_complete ? w_need[3:0] : w_avail;
        w_shr       = 4'd8 - eff_pos - w_k;
        w_chunk     = (i_work.data_byte >> w_shr) & low_mask8(w_k);
        w_acc_new   = (eff_acc << w_k) | {{(MAX_VALUE_BITS-8){1'b0}}, w_chunk};
        w_pos_next  = eff_pos + w_k;
        w_rem       = 4'd8 - w_pos_next;
        w_emit_next = eff_emit + 1'b1;
        w_below     = (w_emit_next < i_cfg.count);
        w_more      = w_below && ({3'b000, w_rem} >= i_cfg.width);
        w_tail      = i_work.data_byte & low_mask8(w_rem);
        w_mask      = {MAX_VALUE_BITS{1'b1}} >> (MAXW - i_cfg.width);
    end

    always_comb begin
        n_acc       = r_acc;
        n_held      = r_held;
        n_emitted   = r_emitted;
        n_mid       = r_mid;
        n_pos       = r_pos;
        o_work_pop  = 1'b0;
        o_res_valid = 1'b0;
        o_res.value        = w_acc_new[63:0] & w_mask[63:0];
        o_res.last_in_byte = !w_more;
        o_res.last_value   = (w_emit_next == i_cfg.count);
        if (i_work_valid) begin
            if (w_done) begin
                // drop the remaining bits of this byte
                o_work_pop = 1'b1;
                n_acc      = eff_acc;
                n_held     = eff_held;
                n_emitted  = eff_emit;
                n_mid      = 1'b0;
            end else if (!w_complete) begin
                o_work_pop = 1'b1;
                n_acc      = w_acc_new;
                n_held     = eff_held + {3'b000, w_k};
                n_emitted  = eff_emit;
                n_mid      = 1'b0;
            end else if (i_res_ready) begin
                o_res_valid = 1'b1;
                n_emitted   = w_emit_next;
                if (w_more) begin
                    n_acc  = '0;
                    n_held = '0;
                    n_mid  = 1'b1;
                    n_pos  = w_pos_next;
                end else begin
                    o_work_pop = 1'b1;
                    n_mid      = 1'b0;
                    if (w_below) begin
                        n_acc  = {{(MAX_VALUE_BITS-8){1'b0}}, w_tail};
                        n_held = {3'b000, w_rem};
                    end else begin
                        n_acc  = '0;
                        n_held = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_held    <= '0;
            r_emitted <= '0;
            r_mid     <= 1'b0;
            r_pos     <= '0;
        end else begin
            r_acc     <= n_acc;
            r_held    <= n_held;
            r_emitted <= n_emitted;
            r_mid     <= n_mid;
            r_pos     <= n_pos;
        end
    end

    `FWBU_ASSERT_IMPLY(a_mid_has_byte, i_clk, i_rst_n, r_mid, i_work_valid, "byte lost mid-way")
    `FWBU_ASSERT_IMPLY(a_mid_pos_range, i_clk, i_rst_n, r_mid, (r_pos != 4'd0) && (r_pos < 4'd8), "bad bit position")
    `FWBU_ASSERT_NEXT(a_more_stays, i_clk, i_rst_n, o_res_valid && !o_res.last_in_byte, r_mid, "byte left early")

endmodule

`default_nettype wire

[rtl/core/fwbu_rq.sv]
`default_nettype none
`include "assert_macros.svh"

module fwbu_rq (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_res_valid,
    output logic            o_res_ready,
    input  fwbu_pkg::t_out  i_res,
    output logic            o_empty,
    input  wire             i_pop,
    output fwbu_pkg::t_out  o_out
);
    import fwbu_pkg::*;

    t_out       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic       w_push;
    logic       w_pop;

    assign o_res_ready = (r_count != 2'd2);
    assign o_empty     = (r_count == 2'd0);
    assign o_out       = r_mem[r_rd_ptr];
    assign w_push      = i_res_valid && o_res_ready;
    assign w_pop       = i_pop && !o_empty;

    always_comb begin
        n_count = r_count;
        case ({w_push, w_pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_res;
        end
    end

    `FWBU_ASSERT_ALWAYS(a_rq_count_bound, i_clk, i_rst_n, r_count != 2'd3, "result queue overflow")

endmodule

`default_nettype wire

[tb/sv/unpack_checker.sv]
`timescale 1ns / 100ps

module unpack_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  logic                                i_full,
    input  fwbu_pkg::t_in                       i_in_item,
    input  logic                                i_empty,
    input  logic                                i_pop,
    input  fwbu_pkg::t_out                      i_out_item,
    input  logic                                i_cfg_wr_en,
    input  logic [fwbu_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [fwbu_pkg::CFG_DATA_BITS-1:0]  i_cfg_wdata,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_checked
);
    import fwbu_pkg::*;

    logic [WIDTH_BITS-1:0]  width_reg;
    logic [OFFSET_BITS-1:0] offset_reg;
    logic [COUNT_BITS-1:0]  count_reg;

    logic [63:0]            acc;
    logic [WIDTH_BITS-1:0]  held;
    logic [COUNT_BITS-1:0]  emitted;

    t_out pending_values[$];
    int   fails = 0;
    int   checked = 0;

    function automatic void unpack_byte(input t_in req);
        t_out        produced [8];
        int          n;
        int          skip;
        int          w;
        int          b;
        int          k;
        logic [63:0] mask;
        w = (width_reg == '0) ? 1 :
            (width_reg > WIDTH_BITS'(MAX_VALUE_BITS)) ? MAX_VALUE_BITS : int'(width_reg);
        mask = (w >= 64) ? '1 : (64'd1 << w) - 64'd1;
        n = 0;
        skip = 0;
        if (req.first_byte) begin
            acc     = '0;
            held    = '0;
            emitted = '0;
            skip    = int'(offset_reg);
        end
        for (b = 7; b >= 0; b--) begin
            if (7 - b < skip) continue;
            if (emitted >= count_reg) break;
            acc  = {acc[62:0], req.data_byte[b]};
            held = held + 7'd1;
            if (int'(held) >= w) begin
                emitted = emitted + 24'd1;
                produced[n].value        = acc & mask;
                produced[n].last_in_byte = 1'b0;
                produced[n].last_value   = (emitted == count_reg);
                n++;
                acc  = '0;
                held = '0;
            end
        end
        for (k = 0; k < n; k++) begin
            produced[k].last_in_byte = (k == n - 1);
            pending_values.push_back(produced[k]);
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_out want;
        if (!i_rst_n) begin
            width_reg  = 7'd8;
            offset_reg = '0;
            count_reg  = '0;
            acc        = '0;
            held       = '0;
            emitted    = '0;
            pending_values.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_VALUE_WIDTH:      width_reg  = i_cfg_wdata[WIDTH_BITS-1:0];
                    REG_START_BIT_OFFSET: offset_reg = i_cfg_wdata[OFFSET_BITS-1:0];
                    REG_VALUE_COUNT:      count_reg  = i_cfg_wdata[COUNT_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_push && !i_full) begin
                unpack_byte(i_in_item);
            end
            if (i_pop && !i_empty) begin
                if (pending_values.size() == 0) begin
                    $display("%0t: unexpected value, expected none, actual %h/%b/%b",
                             $time, i_out_item.value, i_out_item.last_in_byte,
                             i_out_item.last_value);
                    fails++;
                end else begin
                    want = pending_values.pop_front();
                    checked++;
                    if (i_out_item.value !== want.value) begin
                        $display("%0t: value mismatch, expected %h actual %h",
                                 $time, want.value, i_out_item.value);
                        fails++;
                    end
                    if (i_out_item.last_in_byte !== want.last_in_byte) begin
                        $display("%0t: last_in_byte mismatch, expected %b actual %b",
                                 $time, want.last_in_byte, i_out_item.last_in_byte);
                        fails++;
                    end
                    if (i_out_item.last_value !== want.last_value) begin
                        $display("%0t: last_value mismatch, expected %b actual %b",
                                 $time, want.last_value, i_out_item.last_value);
                        fails++;
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= pending_values.size();
        o_checked    <= checked;
    end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps

module tb;
    import fwbu_pkg::*;

    localparam int RANDOM_ITEMS = 128;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 2000;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      push;
    logic                      full;
    t_in                       in_item;
    logic                      empty;
    logic                      pop;
    t_out                      out_item;
    logic                      cfg_wr_en;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_wdata;

    int fail_count;
    int pending;
    int checked;

    bit tx_idle = 1'b1;
    bit hold_req = 1'b0;
    int bytes_sent = 0;
    int settings = 0;

    fixed_width_bit_unpacker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_item   (in_item),
        .empty       (empty),
        .pop         (pop),
        .o_out_item  (out_item),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    unpack_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_in_item    (in_item),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_out_item   (out_item),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_index  (cfg_index),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic send_request(input logic [7:0] data, input logic first);
        int gap;
        gap = tx_idle ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push    <= 1'b1;
        in_item <= '{data_byte: data, first_byte: first};
        do @(posedge i_clk); while (full);
        bytes_sent++;
    endtask

    task automatic configure(input logic [6:0] w, input logic [2:0] off,
                             input logic [23:0] cnt);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_VALUE_WIDTH;
        cfg_wdata <= 24'(w);
        @(posedge i_clk);
        cfg_index <= REG_START_BIT_OFFSET;
        cfg_wdata <= 24'(off);
        @(posedge i_clk);
        cfg_index <= REG_VALUE_COUNT;
        cfg_wdata <= cnt;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        settings++;
    endtask

    task automatic settle();
        push <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // receiver: random pop gaps, one long hold-off on request
    initial begin
        int gap;
        int pops;
        bit rx_idle;
        bit hold_done;
        pop <= 1'b0;
        rx_idle = 1'b1;
        hold_done = 1'b0;
        pops = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            gap = rx_idle ? $urandom_range(0, 15) : 0;
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            pops++;
            if (pops % 16 == 0) rx_idle = ($urandom_range(0, 2) != 0);
        end
    end

    initial begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty) || cfg_wr_en) stall_cycles = 0;
            else stall_cycles++;
        end
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        logic [7:0]  pattern [12];
        logic [6:0]  w;
        logic [2:0]  off;
        logic [23:0] cnt;
        int          w_eff;
        int          nbytes;
        int          random_items;
        int          k;
        bit          pressure_done;

        pattern = '{8'hFF, 8'h00, 8'hAA, 8'h55, 8'h0F, 8'hF0,
                    8'h01, 8'h80, 8'hC3, 8'h3C, 8'h96, 8'h69};
        i_rst_n   <= 1'b0;
        push      <= 1'b0;
        in_item   <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_VALUE_WIDTH;
        cfg_wdata <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: count zero drops everything
        send_request(8'hFF, 1'b0);
        send_request(8'h00, 1'b1);
        settle();

        // no first byte yet: continue the empty array, then overrun the count
        configure(7'd8, 3'd0, 24'd3);
        send_request(8'hA5, 1'b0);
        send_request(8'h00, 1'b0);
        send_request(8'hFF, 1'b0);
        send_request(8'h12, 1'b0);
        settle();

        // single-bit values, full offset on the first byte only
        configure(7'd1, 3'd7, 24'd9);
        send_request(8'h81, 1'b1);
        send_request(8'h55, 1'b0);
        send_request(8'hFF, 1'b0);
        settle();

        // oversized width clamps to 64, then width zero lands mid-value
        configure(7'd100, 3'd0, 24'hFFFFFF);
        for (k = 0; k < 12; k++) send_request(pattern[k], k == 0);
        settle();
        configure(7'd0, 3'd7, 24'hFFFFFF);
        send_request(8'h5A, 1'b0);
        settle();

        random_items = 0;
        pressure_done = 1'b0;
        while (random_items < RANDOM_ITEMS) begin
            if (!pressure_done) begin
                w = 7'd3;
                off = 3'($urandom_range(0, 7));
                cnt = 24'd40;
                tx_idle = 1'b0;
                hold_req = 1'b1;
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: w = 7'($urandom_range(1, 12));
                    6, 7:             w = 7'($urandom_range(13, 64));
                    8:                w = 7'($urandom_range(65, 127));
                    default:          w = 7'd0;
                endcase
                off = 3'($urandom_range(0, 7));
                tx_idle = ($urandom_range(0, 3) != 0);
            end
            w_eff = (w == 0) ? 1 : (w > 64) ? 64 : int'(w);
            if (pressure_done) begin
                cnt = (w_eff <= 16) ? 24'($urandom_range(1, 12)) : 24'($urandom_range(1, 3));
                if ($urandom_range(0, 7) == 0) cnt = 24'($urandom_range(0, 24'hFFFFFF));
            end
            configure(w, off, cnt);
            repeat ($urandom_range(1, 3)) begin
                nbytes = (int'(off) + w_eff * int'(cnt) + 7) / 8;
                if (nbytes > 24) nbytes = 24;
                if (nbytes < 1) nbytes = 1;
                if (pressure_done && $urandom_range(0, 5) == 0) begin
                    nbytes = $urandom_range(1, nbytes);
                end
                for (k = 0; k < nbytes; k++) begin
                    send_request(8'($urandom_range(0, 255)), k == 0);
                end
                random_items += nbytes;
                if ($urandom_range(0, 3) == 0) begin
                    nbytes = $urandom_range(1, 3);
                    for (k = 0; k < nbytes; k++) begin
                        send_request(8'($urandom_range(0, 255)), 1'b0);
                    end
                    random_items += nbytes;
                end
            end
            settle();
            pressure_done = 1'b1;
        end

        $display("Run: %0d bytes sent, %0d values checked, %0d register settings",
                 bytes_sent, checked, settings);
        $display("Widths 0..127, offsets 0..7, zero and full counts, long receiver hold-off");
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
